### sv/sbs_pkg.sv
`timescale 1ns / 1ps
package sbs_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FOUND = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic probe;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic hit;
    logic cont;
  } dp_sts_t;

endpackage

### sv/sorted_table_binary_search_top.sv
`timescale 1ns / 1ps
// sorted table with binary search over signed 32-bit entries
// input channel: in_valid_i / in_stall_o with command_i and value_i; one
//   transaction is taken when valid is high and stall is low
// commands: append stores value at the next free slot and returns its index,
//   or table full when no slot is left; search returns found with the index
//   of the first match on the probe path, or not found; clear empties the
//   table (contents stay, only the count drops); the unused code is a no-op
// output channel: out_valid_o / out_stall_i with status_o and index_o, one
//   result transaction per input transaction, in order
// order of work: append, clear and no-op go from accept straight to the finish
//   state; a search on a non-empty table reads the first midpoint at accept, then
//   probes (up to clog2(entries+1) probes, 11 for a full 1024-entry table), then finishes
// throughput: one transaction at a time, the next input is taken the cycle
//   after the result moves to the output register
// a waiting result sits in the output register, so an input transaction can
//   still be taken while the receiver stalls; only the next result then waits
// reset clears the entry count, the state and the output valid; the table is not cleared
module sorted_table_binary_search_top
  import sbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CMD_W-1:0]          command_i,
  input  logic signed [VALUE_W-1:0] value_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [INDEX_W-1:0]        index_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  // sequencer: accept, probe loop, hand-off to the output register
  sbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (ctrl_cmd)
  );

  // table memory, entry count, search bounds and result registers
  sbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ctrl_cmd),
    .command_i (command_i),
    .value_i   (value_i),
    .sts_o     (dp_sts),
    .status_o  (status_o),
    .index_o   (index_o)
  );

endmodule

### sv/sbs_ctrl.sv
`timescale 1ns / 1ps
module sbs_ctrl
  import sbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] command_i,
  input  logic             out_stall_i,
  input  dp_sts_t          sts_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output ctrl_cmd_t        cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_load;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((command_i == CMD_SEARCH) && !sts_i.empty) begin
            state_d = S_PROBE;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_PROBE: begin
        if (sts_i.hit || !sts_i.cont) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.accept   = accept;
    cmd_o.probe    = (state_q == S_PROBE);
    cmd_o.out_load = out_load;
    in_stall_o     = (state_q != S_IDLE);
    out_valid_o    = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_empty_search_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == CMD_SEARCH) && sts_i.empty |=> state_q == S_FINISH)
    else $error("search on empty table did not finish at once");

  a_probe_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) && (sts_i.hit || !sts_i.cont) |=> state_q == S_FINISH)
    else $error("probe loop did not stop on hit or crossed bounds");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (state_q == S_IDLE))
    else $error("result load did not present a transaction");

endmodule

### sv/sbs_datapath.sv
`timescale 1ns / 1ps
module sbs_datapath
  import sbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  input  logic [CMD_W-1:0]          command_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output dp_sts_t                   sts_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [INDEX_W-1:0]        index_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic signed [VALUE_W-1:0] table_mem [0:TABLE_DEPTH-1];
  logic signed [VALUE_W-1:0] rd_data_q;
  logic signed [VALUE_W-1:0] key_q;
  logic [CW-1:0]             count_q;
  logic [CW-1:0]             lo_q;
  logic [CW-1:0]             hi_q;
  logic [AW-1:0]             mid_q;
  status_e                   res_status_q;
  logic [INDEX_W-1:0]        res_index_q;
  status_e                   out_status_q;
  logic [INDEX_W-1:0]        out_index_q;

  logic          full;
  logic          wr_en;
  logic          greater;
  logic [CW-1:0] mid_ext;
  logic [SW-1:0] sum_lt;
  logic [SW-1:0] sum_gt;
  logic [AW-1:0] mid0;
  logic [AW-1:0] mid_lt;
  logic [AW-1:0] mid_gt;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] rd_addr;

  assign full    = (count_q == CW'(TABLE_DEPTH));
  assign wr_en   = cmd_i.accept && (command_i == CMD_APPEND) && !full;
  assign greater = key_q > rd_data_q;
  assign mid_ext = CW'(mid_q);
  assign cnt_m1  = count_q - CW'(1);
  assign mid0    = AW'(cnt_m1 >> 1);
  // candidate midpoints for both compare outcomes, picked after the compare
  assign sum_lt  = SW'(lo_q) + SW'(mid_ext) - SW'(1);
  assign sum_gt  = SW'(mid_ext) + SW'(hi_q);
  assign mid_lt  = AW'(sum_lt >> 1);
  assign mid_gt  = AW'(sum_gt >> 1);
  assign rd_addr = cmd_i.accept ? mid0 : (greater ? mid_gt : mid_lt);

  always_comb begin
    sts_o.empty = (count_q == '0);
    sts_o.hit   = (key_q == rd_data_q);
    sts_o.cont  = greater ? ((SW'(mid_ext) + SW'(1)) < SW'(hi_q)) : (lo_q < mid_ext);
  end

  // table storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[count_q[AW-1:0]] <= value_i;
    end
    rd_data_q <= table_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.accept) begin
      if (command_i == CMD_CLEAR) begin
        count_q <= '0;
      end else if (wr_en) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q       <= value_i;
      lo_q        <= '0;
      hi_q        <= count_q;
      mid_q       <= mid0;
      res_index_q <= '0;
      unique case (command_i)
        CMD_APPEND: begin
          if (full) begin
            res_status_q <= ST_FULL;
          end else begin
            res_status_q <= ST_OK;
            res_index_q  <= INDEX_W'(count_q);
          end
        end
        CMD_SEARCH: res_status_q <= ST_MISS;
        default:    res_status_q <= ST_OK;
      endcase
    end else if (cmd_i.probe) begin
      if (sts_o.hit) begin
        res_status_q <= ST_FOUND;
        res_index_q  <= INDEX_W'(mid_q);
      end else if (greater) begin
        lo_q  <= mid_ext + CW'(1);
        mid_q <= mid_gt;
      end else begin
        hi_q  <= mid_ext;
        mid_q <= mid_lt;
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
    end
  end

  assign status_o = out_status_q;
  assign index_o  = out_index_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe |-> (lo_q <= mid_ext) && (mid_ext < hi_q) && (hi_q <= count_q))
    else $error("probe outside search bounds");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.accept |=> $stable(count_q))
    else $error("entry count changed without a transaction");

endmodule

### bench/sorted_table_binary_search_top_tb.sv
`timescale 1ns / 1ps
module sorted_table_binary_search_top_tb
  import sbs_pkg::*;
();

  localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
  // worst case is far below this: ~1450 transactions, one at a time in the block,
  // plus random gaps, random stalls and two long receiver hold-offs
  localparam int CYCLE_LIMIT    = 200000;
  localparam int TAIL_CYCLES    = 20;
  localparam int TOTAL_REQUESTS = 1450;
  localparam int HOLD_CYCLES    = 300;
  // window of transactions in which neither side idles
  localparam int BUSY_FIRST     = 300;
  localparam int BUSY_LAST      = 700;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic               drain;  // hold this transaction until every result is back
  } request_t;

  typedef struct packed {
    status_e            status;
    logic [INDEX_W-1:0] index;
  } response_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall_o;
  logic [CMD_W-1:0]          command     = CMD_APPEND;
  logic signed [VALUE_W-1:0] value       = '0;
  logic                      out_valid_o;
  logic                      out_stall   = 1'b0;
  logic [STATUS_W-1:0]       status_o;
  logic [INDEX_W-1:0]        index_o;

  // table image kept by the predictor
  logic signed [VALUE_W-1:0] table_image [DEPTH];
  int                        table_fill  = 0;

  request_t                  request_q[$];
  response_t                 pending_responses[$];
  logic [VALUE_W-1:0]        phase_keys[$];

  int  requests_sent  = 0;
  int  responses_seen = 0;
  int  mismatches     = 0;
  int  cycle_count    = 0;
  int  hold_left      = 0;
  bit  first_hold_done  = 1'b0;
  bit  second_hold_done = 1'b0;

  sorted_table_binary_search_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .command_i   (command),
    .value_i     (value),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .status_o    (status_o),
    .index_o     (index_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // expected response of one accepted transaction, updates the table image
  function automatic response_t table_response(logic [CMD_W-1:0] cmd,
                                               logic signed [VALUE_W-1:0] key);
    response_t rsp;
    int        lo;
    int        hi;
    int        mid;
    bit        hit;
    rsp.status = ST_OK;
    rsp.index  = '0;
    case (cmd)
      CMD_APPEND: begin
        if (table_fill >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          table_image[table_fill] = key;
          rsp.index  = table_fill[INDEX_W-1:0];
          table_fill = table_fill + 1;
        end
      end
      CMD_SEARCH: begin
        // inclusive bounds lo .. hi-1, midpoint rounds down
        lo  = 0;
        hi  = table_fill;
        hit = 1'b0;
        while (lo < hi && !hit) begin
          mid = (lo + hi - 1) / 2;
          if (key == table_image[mid]) begin
            hit       = 1'b1;
            rsp.index = mid[INDEX_W-1:0];
          end else if (key > table_image[mid]) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
        rsp.status = hit ? ST_FOUND : ST_MISS;
      end
      CMD_CLEAR: begin
        table_fill = 0;  // contents stay, only the count drops
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  function automatic void queue_request(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val,
                                        bit drain);
    request_t req;
    req.cmd   = cmd;
    req.value = val;
    req.drain = drain;
    request_q.push_back(req);
  endfunction

  // appends n non-decreasing values, steps of 0 give duplicate keys
  function automatic void load_ascending(int n, longint start, int unsigned max_step);
    longint v;
    v = start;
    for (int k = 0; k < n; k++) begin
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      queue_request(CMD_APPEND, v[VALUE_W-1:0], 1'b0);
      phase_keys.push_back(v[VALUE_W-1:0]);
      v = v + longint'($urandom_range(max_step, 0));
    end
  endfunction

  // mostly hits and near misses, some random keys and a little noise
  function automatic void queue_searches(int m);
    logic [VALUE_W-1:0] key;
    logic [CMD_W-1:0]   noise_cmd;
    int unsigned        pick;
    for (int k = 0; k < m; k++) begin
      pick = $urandom_range(99);
      if (phase_keys.size() != 0 && pick < 60) begin
        key = phase_keys[$urandom_range(phase_keys.size() - 1)];
      end else if (phase_keys.size() != 0 && pick < 85) begin
        key = phase_keys[$urandom_range(phase_keys.size() - 1)];
        key = pick[0] ? key + 32'd1 : key - 32'd1;
      end else begin
        key = $urandom();
      end
      if (pick >= 95) begin
        // noise: any command, appends here break the ascending order
        noise_cmd = CMD_W'($urandom_range(3));
        queue_request(noise_cmd, $urandom(), 1'b0);
      end else begin
        queue_request(CMD_SEARCH, key, 1'b0);
      end
    end
  endfunction

  // clear, load a small sorted table, then search it
  function automatic void queue_small_phase();
    int n;
    queue_request(CMD_CLEAR, $urandom(), $urandom_range(3) == 0);
    phase_keys.delete();
    n = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
    if ($urandom_range(1) == 0) begin
      // dense keys near zero with duplicates
      load_ascending(n, longint'($urandom_range(100)) - 50, 3);
    end else begin
      // keys spread over the whole signed range
      load_ascending(n, -64'sd2147483648 + longint'($urandom_range(32'h4000_0000)),
                     32'h0200_0000);
    end
    queue_searches($urandom_range(2 * n, n));
  endfunction

  // stimulus and end of run
  initial begin
    // empty table, signed extremes, misses on both sides
    queue_request(CMD_SEARCH, 32'h0000_0000, 1'b0);
    queue_request(CMD_APPEND, 32'h8000_0000, 1'b0);
    queue_request(CMD_APPEND, 32'hffff_ffff, 1'b0);
    queue_request(CMD_APPEND, 32'h0000_0000, 1'b0);
    queue_request(CMD_APPEND, 32'h0000_0001, 1'b0);
    queue_request(CMD_APPEND, 32'h7fff_ffff, 1'b0);
    queue_request(CMD_SEARCH, 32'h8000_0000, 1'b0);
    queue_request(CMD_SEARCH, 32'h7fff_ffff, 1'b0);
    queue_request(CMD_SEARCH, 32'h0000_0000, 1'b0);
    queue_request(CMD_SEARCH, 32'h0000_0005, 1'b0);
    queue_request(CMD_SEARCH, 32'hffff_fffe, 1'b0);
    // unused command code
    queue_request(CMD_NOP, 32'hdead_beef, 1'b0);
    // out of order append after the largest value
    queue_request(CMD_APPEND, 32'h0000_0007, 1'b0);
    queue_request(CMD_SEARCH, 32'h0000_0007, 1'b0);
    queue_request(CMD_SEARCH, 32'h7fff_ffff, 1'b0);
    // clear keeps contents but empties the table
    queue_request(CMD_CLEAR, 32'h5555_aaaa, 1'b1);
    queue_request(CMD_SEARCH, 32'h0000_0000, 1'b0);
    // duplicate keys
    queue_request(CMD_APPEND, 32'h0000_0003, 1'b0);
    queue_request(CMD_APPEND, 32'h0000_0003, 1'b0);
    queue_request(CMD_APPEND, 32'h0000_0003, 1'b0);
    queue_request(CMD_SEARCH, 32'h0000_0003, 1'b0);
    queue_request(CMD_APPEND, 32'hffff_fffb, 1'b0);
    queue_request(CMD_SEARCH, 32'hffff_fffb, 1'b0);

    while (request_q.size() < 200) queue_small_phase();

    // fill the whole table, run into full, search the full range of indexes
    queue_request(CMD_CLEAR, 32'h0000_0000, 1'b1);
    phase_keys.delete();
    load_ascending(DEPTH, -64'sd2147483648 + longint'($urandom_range(32'h2000_0000)),
                   32'h0020_0000);
    repeat (3) queue_request(CMD_APPEND, $urandom(), 1'b0);
    queue_searches(40);

    while (request_q.size() < TOTAL_REQUESTS) queue_small_phase();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_valid || pending_responses.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // driver: predicts at acceptance, then offers the next transaction or idles
  always @(posedge clk_i or negedge rst_ni) begin : drive
    int sent_now;
    bit offer;
    if (!rst_ni) begin
      in_valid      <= 1'b0;
      requests_sent <= 0;
    end else begin
      sent_now = requests_sent;
      if (in_valid && !in_stall_o) begin
        pending_responses.push_back(table_response(command, value));
        sent_now = requests_sent + 1;
      end
      requests_sent <= sent_now;
      // a stalled transaction stays on the bus untouched
      if (!in_valid || !in_stall_o) begin
        offer = request_q.size() != 0 &&
                ($urandom_range(99) >= 30 || (sent_now >= BUSY_FIRST && sent_now < BUSY_LAST));
        // pause until the block has drained completely
        if (offer && request_q[0].drain && sent_now != responses_seen) offer = 1'b0;
        if (offer) begin
          in_valid <= 1'b1;
          command  <= request_q[0].cmd;
          value    <= request_q[0].value;
          void'(request_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs, the sender keeps offering so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (!first_hold_done && responses_seen >= 100) begin
      first_hold_done <= 1'b1;
      hold_left       <= HOLD_CYCLES;
    end else if (!second_hold_done && responses_seen >= 1250) begin
      second_hold_done <= 1'b1;
      hold_left        <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compares each result transaction with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : watch
    response_t want;
    if (!rst_ni) begin
      out_stall      <= 1'b0;
      responses_seen <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        responses_seen <= responses_seen + 1;
        if (pending_responses.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status %0d index %0d", status_o, index_o);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_responses.pop_front();
          if (status_o !== want.status || index_o !== want.index) begin
            if (mismatches < 10)
              $display({"mismatch on result %0d: expected status %0d index %0d,",
                        " got status %0d index %0d"},
                       responses_seen, want.status, want.index, status_o, index_o);
            mismatches <= mismatches + 1;
          end
        end
      end
      out_stall <= hold_left != 0 ||
                   (!(responses_seen >= BUSY_FIRST && responses_seen < BUSY_LAST) &&
                    $urandom_range(99) < 30);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
